>>> hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/fds_pkg.sv
`default_nettype none
package fds_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = 7;

    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_POP   = 4'd1;
    localparam logic [3:0] CMD_TOP   = 4'd2;
    localparam logic [3:0] CMD_SWAP  = 4'd3;
    localparam logic [3:0] CMD_2SWAP = 4'd4;
    localparam logic [3:0] CMD_ADD   = 4'd5;
    localparam logic [3:0] CMD_ROT   = 4'd6;
    localparam logic [3:0] CMD_DROP  = 4'd7;
    localparam logic [3:0] CMD_2DROP = 4'd8;
    localparam logic [3:0] CMD_DUP   = 4'd9;
    localparam logic [3:0] CMD_2DUP  = 4'd10;
    localparam logic [3:0] CMD_SUB   = 4'd11;
    localparam logic [3:0] CMD_MULT  = 4'd12;
    localparam logic [3:0] CMD_DIV   = 4'd13;
    localparam logic [3:0] CMD_OVER  = 4'd14;
    localparam logic [3:0] CMD_2OVER = 4'd15;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // read entry at offset into operand slot
        OP_WRITE,    // write slot value at offset
        OP_ALU,      // compute result into slot 2
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_SETCNT,
        OP_PEEK      // read top for result value
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] off;     // position below old top (negative offsets via grow)
        logic       above;   // offset counts upward from old top
        logic [1:0] slot;
        logic [1:0] src;
        logic [3:0] cmd;
        logic [CW-1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic          div_done;
        logic          divisor_zero;
        logic [CW-1:0] count;
    } dp_stat_t;

    function automatic logic [2:0] need_of(input logic [3:0] c);
        case (c)
            CMD_PUSH: need_of = 3'd0;
            CMD_POP, CMD_TOP, CMD_DROP, CMD_DUP: need_of = 3'd1;
            CMD_2SWAP, CMD_2OVER: need_of = 3'd4;
            CMD_ROT: need_of = 3'd3;
            default: need_of = 3'd2;
        endcase
    endfunction

    function automatic logic [1:0] grow_of(input logic [3:0] c);
        case (c)
            CMD_PUSH, CMD_DUP, CMD_OVER: grow_of = 2'd1;
            CMD_2DUP, CMD_2OVER: grow_of = 2'd2;
            default: grow_of = 2'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> hdl/forth_data_stack_unit.sv
`default_nettype none
// Forth data stack: executes one Forth word per command beat.
// A command beat is taken when start is high and busy is low; cmd and
// push_value are sampled then. Busy stays high until the result beat.
// The result beat is a one-cycle done strobe carrying ok, status,
// result_value and depth; the receiver cannot stall, so it must capture it.
// A word that reads n top entries and writes w raises done after the serial
// walk of those up to four top entries through the single-address stack
// memory (one access a cycle) and the final read of the new top.
// Failing words (status too few / full) leave the stack untouched; div by
// zero skips the divider. Div runs a one-bit-a-cycle restoring divider.
// The next beat can be taken at the edge that ends done; a new word is not
// taken before the last one has returned its result.
// stack_limit is written through cfg_we / cfg_data; the user must do so only while
// the block is idle, as the block does not enforce it. Reset sets it to 64 and the
// depth to 0. The store holds no reset and needs no clearing pass.
module forth_data_stack_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         cmd,
    input  wire logic signed [31:0] push_value,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_data,
    output logic                    done,
    output logic                    ok,
    output logic [1:0]              status,
    output logic signed [31:0]      result_value,
    output logic [6:0]              depth
);
    logic [6:0] limit_reg;
    fds_pkg::dp_cmd_t  dcmd;
    fds_pkg::dp_stat_t stat;
    logic signed [31:0] peek_value;
    logic signed [31:0] push_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 7'd64;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            push_hold_reg <= push_value;
    end

    fds_control u_ctl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .stack_limit(limit_reg), .stat(stat), .peek_value(peek_value),
        .dcmd(dcmd), .busy(busy), .done(done), .ok(ok), .status(status),
        .result_value(result_value), .depth(depth)
    );

    fds_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .dcmd(dcmd), .push_value(push_hold_reg),
        .stat(stat), .peek_value(peek_value)
    );
endmodule
`default_nettype wire

>>> hdl/fds_datapath.sv
`default_nettype none
module fds_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fds_pkg::dp_cmd_t           dcmd,
    input  wire logic signed [31:0]         push_value,
    output fds_pkg::dp_stat_t               stat,
    output logic signed [31:0]              peek_value
);
    logic [31:0] mem [fds_pkg::DEPTH];
    logic [31:0] rd_reg;
    logic [31:0] opnd_reg [4];
    logic [fds_pkg::CW-1:0] cnt_reg;
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic        neg_reg;
    logic [5:0]  it_reg;
    logic [fds_pkg::CW:0] idx_full;
    logic [fds_pkg::AW-1:0] idx;
    logic [31:0] wdata, alu;
    logic [32:0] trial;
    logic [63:0] prod;
    logic        load_pend_reg;
    logic [1:0]  load_slot_reg;

    always_comb
    begin
        if (dcmd.above)
            idx_full = {1'b0, cnt_reg} + {5'd0, dcmd.off};
        else
            idx_full = {1'b0, cnt_reg} - {5'd0, dcmd.off} - 8'd1;
        idx = idx_full[fds_pkg::AW-1:0];
        wdata = (dcmd.src == 2'd3 && dcmd.cmd == fds_pkg::CMD_PUSH)
            ? push_value : opnd_reg[dcmd.src];
        prod = opnd_reg[0] * opnd_reg[1];
        case (dcmd.cmd)
            fds_pkg::CMD_ADD:  alu = opnd_reg[1] + opnd_reg[0];
            fds_pkg::CMD_SUB:  alu = opnd_reg[1] - opnd_reg[0];
            fds_pkg::CMD_MULT: alu = prod[31:0];
            default:           alu = opnd_reg[0];
        endcase
        trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.op == fds_pkg::OP_WRITE)
            mem[idx] <= wdata;
        rd_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            load_pend_reg <= 1'b0;
            load_slot_reg <= '0;
            it_reg <= '0;
        end
        else
        begin
            load_pend_reg <= (dcmd.op == fds_pkg::OP_LOAD);
            load_slot_reg <= dcmd.slot;
            if (load_pend_reg)
                opnd_reg[load_slot_reg] <= rd_reg;
            case (dcmd.op)
                fds_pkg::OP_SETCNT: cnt_reg <= dcmd.cnt;
                fds_pkg::OP_ALU:    opnd_reg[2] <= alu;
                fds_pkg::OP_DIV_INIT:
                begin
                    neg_reg <= opnd_reg[1][31] ^ opnd_reg[0][31];
                    quo_reg <= opnd_reg[1][31] ? -opnd_reg[1] : opnd_reg[1];
                    dvs_reg <= opnd_reg[0][31] ? -opnd_reg[0] : opnd_reg[0];
                    rem_reg <= '0;
                    it_reg <= '0;
                end
                fds_pkg::OP_DIV_STEP:
                begin
                    if (!trial[32])
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 6'd1;
                end
                fds_pkg::OP_DIV_FIX:
                    opnd_reg[2] <= neg_reg ? -quo_reg : quo_reg;
                default: ;
            endcase
        end
    end

    assign stat.div_done = (it_reg == 6'd31) && (dcmd.op == fds_pkg::OP_DIV_STEP);
    assign stat.divisor_zero = (opnd_reg[0] == 32'd0);
    assign stat.count = cnt_reg;
    assign peek_value = opnd_reg[3];
endmodule
`default_nettype wire

>>> hdl/fds_control.sv
`default_nettype none
`include "assert_macros.svh"
module fds_control (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [3:0]             cmd,
    input  wire logic [6:0]             stack_limit,
    input  wire fds_pkg::dp_stat_t      stat,
    input  wire logic signed [31:0]     peek_value,
    output fds_pkg::dp_cmd_t            dcmd,
    output logic                        busy,
    output logic                        done,
    output logic                        ok,
    output logic [1:0]                  status,
    output logic signed [31:0]          result_value,
    output logic [6:0]                  depth
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_WAIT, S_EXEC, S_DIV, S_FIX, S_WRITE, S_PEEK, S_PW, S_PW2, S_PW3,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [3:0] cmd_reg;
    logic [2:0] step_reg;
    logic [1:0] st_reg;
    logic [6:0] newcnt_reg;
    logic       explicit_reg;
    logic [6:0] lim;
    logic [7:0] sum;

    // per word: loads (offset->slot), writes (src->offset/above)
    logic [2:0] nload, nwrite;
    logic [2:0] woff;
    logic       wabove;
    logic [1:0] wsrc;
    logic [6:0] wcnt;

    always_comb
    begin
        lim = (stack_limit < 7'(fds_pkg::DEPTH)) ? stack_limit : 7'(fds_pkg::DEPTH);
        sum = {1'b0, stat.count} + {6'd0, fds_pkg::grow_of(cmd)};
        nload = 3'd0;
        case (cmd_reg)
            fds_pkg::CMD_PUSH, fds_pkg::CMD_DROP, fds_pkg::CMD_2DROP: nload = 3'd0;
            fds_pkg::CMD_POP, fds_pkg::CMD_TOP, fds_pkg::CMD_DUP: nload = 3'd1;
            fds_pkg::CMD_ROT: nload = 3'd3;
            fds_pkg::CMD_2SWAP, fds_pkg::CMD_2OVER: nload = 3'd4;
            default: nload = 3'd2;
        endcase
        // writes indexed by step_reg
        nwrite = 3'd0;
        woff = 3'd0;
        wabove = 1'b0;
        wsrc = 2'd0;
        case (cmd_reg)
            fds_pkg::CMD_PUSH:
            begin
                nwrite = 3'd1; wabove = 1'b1; wsrc = 2'd3;
            end
            fds_pkg::CMD_SWAP:
            begin
                nwrite = 3'd2; woff = step_reg; wsrc = step_reg[0] ? 2'd0 : 2'd1;
            end
            fds_pkg::CMD_2SWAP:
            begin
                nwrite = 3'd4; woff = step_reg;
                wsrc = 2'(step_reg + 3'd2);
            end
            fds_pkg::CMD_ROT:
            begin
                nwrite = 3'd3; woff = step_reg;
                wsrc = (step_reg == 3'd0) ? 2'd2 : 2'(step_reg - 3'd1);
            end
            fds_pkg::CMD_ADD, fds_pkg::CMD_SUB, fds_pkg::CMD_MULT, fds_pkg::CMD_DIV:
            begin
                nwrite = 3'd1; woff = 3'd1; wsrc = 2'd2;
            end
            fds_pkg::CMD_DUP:
            begin
                nwrite = 3'd1; wabove = 1'b1; wsrc = 2'd0;
            end
            fds_pkg::CMD_OVER:
            begin
                nwrite = 3'd1; wabove = 1'b1; wsrc = 2'd1;
            end
            fds_pkg::CMD_2DUP:
            begin
                nwrite = 3'd2; wabove = 1'b1; woff = step_reg;
                wsrc = step_reg[0] ? 2'd0 : 2'd1;
            end
            fds_pkg::CMD_2OVER:
            begin
                nwrite = 3'd2; wabove = 1'b1; woff = step_reg;
                wsrc = step_reg[0] ? 2'd2 : 2'd3;
            end
            default: ;
        endcase
        wcnt = newcnt_reg;
    end

    // operand slot mapping: slot k = entry k below top, loaded at offset k (POP/TOP load into slot 3)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy <= 1'b0;
            done <= 1'b0;
            dcmd <= '0;
            step_reg <= '0;
            cmd_reg <= '0;
            st_reg <= '0;
            newcnt_reg <= '0;
            explicit_reg <= 1'b0;
            ok <= 1'b0;
            status <= '0;
            result_value <= '0;
            depth <= '0;
        end
        else
        begin
            done <= 1'b0;
            dcmd <= '0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        busy <= 1'b1;
                        cmd_reg <= cmd;
                        step_reg <= '0;
                        explicit_reg <= (cmd == fds_pkg::CMD_POP) || (cmd == fds_pkg::CMD_TOP);
                        if (stat.count < 7'(fds_pkg::need_of(cmd)))
                        begin
                            st_reg <= fds_pkg::ST_UNDER;
                            explicit_reg <= 1'b0;
                            newcnt_reg <= stat.count;
                            state_reg <= S_PEEK;
                        end
                        else if (fds_pkg::grow_of(cmd) != 2'd0 && sum > {1'b0, lim})
                        begin
                            st_reg <= fds_pkg::ST_FULL;
                            explicit_reg <= 1'b0;
                            newcnt_reg <= stat.count;
                            state_reg <= S_PEEK;
                        end
                        else
                        begin
                            st_reg <= fds_pkg::ST_OK;
                            newcnt_reg <= 7'(sum) - 7'(fds_pkg::need_of(cmd) == 3'd0 ? 0 : 0);
                            state_reg <= S_LOAD;
                        end
                    end
                S_LOAD:
                    if (step_reg < nload)
                    begin
                        dcmd.op <= fds_pkg::OP_LOAD;
                        dcmd.off <= step_reg;
                        dcmd.slot <= explicit_reg ? 2'd3 : step_reg[1:0];
                        step_reg <= step_reg + 3'd1;
                    end
                    else
                        state_reg <= S_WAIT;
                S_WAIT:
                begin
                    step_reg <= '0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    dcmd.cmd <= cmd_reg;
                    case (cmd_reg)
                        fds_pkg::CMD_ADD, fds_pkg::CMD_SUB, fds_pkg::CMD_MULT:
                        begin
                            dcmd.op <= fds_pkg::OP_ALU;
                            newcnt_reg <= stat.count - 7'd1;
                            state_reg <= S_WRITE;
                        end
                        fds_pkg::CMD_DIV:
                            if (stat.divisor_zero)
                            begin
                                st_reg <= fds_pkg::ST_DIV0;
                                newcnt_reg <= stat.count - 7'd2;
                                state_reg <= S_PEEK;
                            end
                            else
                            begin
                                dcmd.op <= fds_pkg::OP_DIV_INIT;
                                newcnt_reg <= stat.count - 7'd1;
                                state_reg <= S_DIV;
                            end
                        fds_pkg::CMD_POP, fds_pkg::CMD_DROP:
                        begin
                            newcnt_reg <= stat.count - 7'd1;
                            state_reg <= S_WRITE;
                        end
                        fds_pkg::CMD_2DROP:
                        begin
                            newcnt_reg <= stat.count - 7'd2;
                            state_reg <= S_WRITE;
                        end
                        default: state_reg <= S_WRITE;
                    endcase
                    if (explicit_reg)
                        result_value <= peek_value;
                end
                S_DIV:
                begin
                    dcmd.op <= fds_pkg::OP_DIV_STEP;
                    if (stat.div_done)
                    begin
                        dcmd.op <= fds_pkg::OP_NONE;
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    dcmd.op <= fds_pkg::OP_DIV_FIX;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                    if (step_reg < nwrite)
                    begin
                        dcmd.op <= fds_pkg::OP_WRITE;
                        dcmd.cmd <= cmd_reg;
                        dcmd.off <= woff;
                        dcmd.above <= wabove;
                        dcmd.src <= wsrc;
                        step_reg <= step_reg + 3'd1;
                    end
                    else
                    begin
                        dcmd.op <= fds_pkg::OP_SETCNT;
                        dcmd.cnt <= wcnt;
                        state_reg <= S_PEEK;
                    end
                S_PEEK:
                begin
                    if (newcnt_reg != 7'd0)
                    begin
                        dcmd.op <= fds_pkg::OP_SETCNT;
                        dcmd.cnt <= newcnt_reg;
                    end
                    else
                    begin
                        dcmd.op <= fds_pkg::OP_SETCNT;
                        dcmd.cnt <= newcnt_reg;
                    end
                    state_reg <= S_PW;
                end
                S_PW:
                begin
                    dcmd.op <= fds_pkg::OP_LOAD;
                    dcmd.off <= 3'd0;
                    dcmd.slot <= 2'd3;
                    state_reg <= S_PW2;
                end
                S_PW2:
                    state_reg <= S_PW3;
                S_PW3:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    // peek slot 3 lands this cycle
                    state_reg <= S_IDLE;
                    busy <= 1'b0;
                    done <= 1'b1;
                    ok <= (st_reg == fds_pkg::ST_OK);
                    status <= st_reg;
                    depth <= newcnt_reg;
                    if (!explicit_reg)
                        result_value <= (newcnt_reg == 7'd0) ? 32'sd0 : peek_value;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `ASSERT_IMPL(a_ok_status, done, ok == (status == fds_pkg::ST_OK), "ok and status disagree")
    `ASSERT_IMPL(a_depth_lim, done, depth <= 7'(fds_pkg::DEPTH), "depth above store size")
    `ASSERT_NEXT(a_busy_start, start && !busy, busy, "accepted word did not raise busy")
endmodule
`default_nettype wire
